[hw/rtl/cdiv_pkg.sv]
package cdiv_pkg;

  // field format
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // derived widths
  localparam int PROD_W = 2 * DATA_WIDTH;           // exact product / magnitude sum
  localparam int QUO_W  = DATA_WIDTH + 1;           // quotient bits worth developing
  localparam int NUM_W  = PROD_W + FRAC_BITS;       // numerator scaled by the fraction

  // pipeline shape
  localparam int FRONT_STAGES = 4;
  localparam int PIPE_DEPTH   = FRONT_STAGES + QUO_W + 1;
  localparam int CNT_W        = $clog2(PIPE_DEPTH + 2);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [DATA_WIDTH-1:0]        mag_t;
  typedef logic [PROD_W-1:0]            prod_t;
  typedef logic [QUO_W-1:0]             word_t;
  typedef logic [NUM_W-1:0]             num_t;

  // largest positive field value, used for saturation
  localparam data_t DATA_MAX = data_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});

  // state handed from cell to cell: both lanes share the squared magnitude
  typedef struct packed {
    prod_t y;
    prod_t rem_re;
    prod_t rem_im;
    word_t word_re;
    word_t word_im;
    logic  neg_re;
    logic  neg_im;
    logic  ovf;
  } div_t;

endpackage

[hw/rtl/cdiv_in_if.sv]
interface cdiv_in_if;
  import cdiv_pkg::*;

  logic  valid;
  logic  ready;
  data_t dividend_real;
  data_t dividend_imag;
  data_t divisor_real;
  data_t divisor_imag;

  modport source (
    output valid, dividend_real, dividend_imag, divisor_real, divisor_imag,
    input  ready
  );

  modport sink (
    input  valid, dividend_real, dividend_imag, divisor_real, divisor_imag,
    output ready
  );

endinterface

[hw/rtl/cdiv_out_if.sv]
interface cdiv_out_if;
  import cdiv_pkg::*;

  logic  valid;
  logic  ready;
  data_t quotient_real;
  data_t quotient_imag;
  logic  overflow;

  modport source (
    output valid, quotient_real, quotient_imag, overflow,
    input  ready
  );

  modport sink (
    input  valid, quotient_real, quotient_imag, overflow,
    output ready
  );

endinterface

[hw/rtl/cdiv_front.sv]
module cdiv_front (
  input  logic         clk,
  input  logic         rst,
  cdiv_in_if.sink      din,
  output logic         out_valid,
  input  logic         out_ready,
  output cdiv_pkg::div_t out_data
);
  import cdiv_pkg::*;

  typedef struct packed {
    logic  neg;
    prod_t mag;
  } smag_t;

  function automatic prod_t umul(input mag_t x, input mag_t z);
    return prod_t'(x) * prod_t'(z);
  endfunction

  // signed sum of two sign-magnitude terms, both differences formed side by side
  function automatic smag_t sadd(input logic n1, input prod_t m1,
                                 input logic n2, input prod_t m2);
    logic [PROD_W:0] d12;
    logic [PROD_W:0] d21;
    smag_t           r;
    d12 = {1'b0, m1} - {1'b0, m2};
    d21 = {1'b0, m2} - {1'b0, m1};
    if (n1 == n2) begin
      r.neg = n1;
      r.mag = m1 + m2;
    end else if (!d12[PROD_W]) begin
      r.neg = n1;
      r.mag = d12[PROD_W-1:0];
    end else begin
      r.neg = n2;
      r.mag = d21[PROD_W-1:0];
    end
    return r;
  endfunction

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1: sign and magnitude of each field
  logic nc, nd, na, nb;
  mag_t mc, md, ma, mb;

  // stage 2: the six products
  prod_t aa, bb, ca, db, da, cb;
  logic  s_ca, s_db, s_da, s_cb;

  // stage 3: squared magnitude and both numerators
  prod_t y3;
  smag_t p3, q3;

  // stage 4: scaled numerators split into remainder seed and low bits
  div_t  d4;
  num_t  np_s, nq_s, hp, hq, y_w;

  // hold chain: a stage loads when empty or when its word moves on
  assign rdy4      = !v4 || out_ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign din.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= din.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rdy1) begin
      nc <= din.dividend_real[DATA_WIDTH-1];
      nd <= din.dividend_imag[DATA_WIDTH-1];
      na <= din.divisor_real[DATA_WIDTH-1];
      nb <= din.divisor_imag[DATA_WIDTH-1];
      mc <= din.dividend_real[DATA_WIDTH-1] ? mag_t'(-din.dividend_real)
                                            : mag_t'(din.dividend_real);
      md <= din.dividend_imag[DATA_WIDTH-1] ? mag_t'(-din.dividend_imag)
                                            : mag_t'(din.dividend_imag);
      ma <= din.divisor_real[DATA_WIDTH-1] ? mag_t'(-din.divisor_real)
                                           : mag_t'(din.divisor_real);
      mb <= din.divisor_imag[DATA_WIDTH-1] ? mag_t'(-din.divisor_imag)
                                           : mag_t'(din.divisor_imag);
    end
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rdy2) begin
      aa   <= umul(ma, ma);
      bb   <= umul(mb, mb);
      ca   <= umul(mc, ma);
      db   <= umul(md, mb);
      da   <= umul(md, ma);
      cb   <= umul(mc, mb);
      s_ca <= nc ^ na;
      s_db <= nd ^ nb;
      s_da <= nd ^ na;
      s_cb <= !(nc ^ nb);
    end
  end

  // stage 3 registers
  always_ff @(posedge clk) begin
    if (rdy3) begin
      y3 <= aa + bb;
      p3 <= sadd(s_ca, ca, s_db, db);
      q3 <= sadd(s_da, da, s_cb, cb);
    end
  end

  // seed for the division cells and the up-front range check
  always_comb begin
    np_s         = num_t'(p3.mag) << FRAC_BITS;
    nq_s         = num_t'(q3.mag) << FRAC_BITS;
    hp           = np_s >> QUO_W;
    hq           = nq_s >> QUO_W;
    y_w          = num_t'(y3);
    d4.y         = y3;
    d4.rem_re    = prod_t'(hp);
    d4.rem_im    = prod_t'(hq);
    d4.word_re   = np_s[QUO_W-1:0];
    d4.word_im   = nq_s[QUO_W-1:0];
    d4.neg_re    = p3.neg;
    d4.neg_im    = q3.neg;
    d4.ovf       = (y3 == '0) || (hp >= y_w) || (hq >= y_w);
  end

  // stage 4 registers
  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_data <= d4;
    end
  end

  assign out_valid = v4;

endmodule

[hw/rtl/cdiv_cell.sv]
module cdiv_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cdiv_pkg::div_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cdiv_pkg::div_t out_data
);
  import cdiv_pkg::*;

  logic            vld;
  logic [PROD_W:0] t_re, t_im, y_x;
  logic            ge_re, ge_im;
  div_t            nxt;

  assign in_ready = !vld || out_ready;

  // one restoring step on each lane: bring down a bit, subtract if it fits
  always_comb begin
    y_x         = {1'b0, in_data.y};
    t_re        = {in_data.rem_re, in_data.word_re[QUO_W-1]};
    t_im        = {in_data.rem_im, in_data.word_im[QUO_W-1]};
    ge_re       = t_re >= y_x;
    ge_im       = t_im >= y_x;
    nxt         = in_data;
    nxt.rem_re  = ge_re ? prod_t'(t_re - y_x) : prod_t'(t_re);
    nxt.rem_im  = ge_im ? prod_t'(t_im - y_x) : prod_t'(t_im);
    nxt.word_re = {in_data.word_re[QUO_W-2:0], ge_re};
    nxt.word_im = {in_data.word_im[QUO_W-2:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= nxt;
    end
  end

  assign out_valid = vld;

endmodule

[hw/rtl/cdiv_back.sv]
module cdiv_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cdiv_pkg::div_t in_data,
  cdiv_out_if.source     dout
);
  import cdiv_pkg::*;

  word_t lim_re, lim_im;
  logic  bad;
  data_t res_re, res_im;
  logic  vld;

  // a negative part may reach one step further than a positive one
  always_comb begin
    lim_re = in_data.neg_re ? (word_t'(1) << (DATA_WIDTH - 1))
                            : (word_t'(1) << (DATA_WIDTH - 1)) - word_t'(1);
    lim_im = in_data.neg_im ? (word_t'(1) << (DATA_WIDTH - 1))
                            : (word_t'(1) << (DATA_WIDTH - 1)) - word_t'(1);
    bad    = in_data.ovf || (in_data.word_re > lim_re) || (in_data.word_im > lim_im);
    res_re = in_data.neg_re ? data_t'(mag_t'(0) - in_data.word_re[DATA_WIDTH-1:0])
                            : data_t'(in_data.word_re[DATA_WIDTH-1:0]);
    res_im = in_data.neg_im ? data_t'(mag_t'(0) - in_data.word_im[DATA_WIDTH-1:0])
                            : data_t'(in_data.word_im[DATA_WIDTH-1:0]);
  end

  assign in_ready = !vld || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  // output register, saturated on any overflow
  always_ff @(posedge clk) begin
    if (in_ready) begin
      dout.quotient_real <= bad ? DATA_MAX : res_re;
      dout.quotient_imag <= bad ? DATA_MAX : res_im;
      dout.overflow      <= bad;
    end
  end

  assign dout.valid = vld;

endmodule

[hw/rtl/complex_divider.sv]
// complex_divider: quotient of two complex numbers in signed Q16.16.
// din carries dividend_real/imag and divisor_real/imag; a word is taken on
// a clock edge with din.valid and din.ready both high.  dout carries
// quotient_real/imag and overflow, taken when dout.valid and dout.ready.
// overflow is set, and both parts read as the largest positive value, when
// the divisor is zero or either part does not fit the output format.
// Stages, in order: 4 front stages (split, products, sums, range check),
// 33 division cells each developing one quotient bit for both parts,
// and the output register.  Throughput is one word per cycle while
// the receiver takes words; a stall holds every full stage.
// Every stage loads when it is empty or its word moves on, so bubbles close
// up; while the receiver stalls, up to 38 words are held and din.ready
// stays high until every stage is full.  A synchronous rst empties all
// stages; no other state is kept.
module complex_divider (
  input  logic      clk,
  input  logic      rst,
  cdiv_in_if.sink   din,
  cdiv_out_if.source dout
);
  import cdiv_pkg::*;

  logic [QUO_W:0] vld;
  logic [QUO_W:0] rdy;
  div_t           dat [QUO_W+1];

  // operand preparation
  cdiv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_data  (dat[0])
  );

  // row of division cells
  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    cdiv_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_data   (dat[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_data  (dat[i+1])
    );
  end

  // range check and output register
  cdiv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[QUO_W]),
    .in_ready (rdy[QUO_W]),
    .in_data  (dat[QUO_W]),
    .dout     (dout)
  );

endmodule

[hw/rtl/cdiv_check.sv]
module cdiv_check (
  input logic                  clk,
  input logic                  rst,
  input logic                  din_valid,
  input logic                  din_ready,
  input logic                  dout_valid,
  input logic                  dout_ready,
  input cdiv_pkg::data_t       quotient_real,
  input cdiv_pkg::data_t       quotient_imag,
  input logic                  overflow
);
  import cdiv_pkg::*;

  logic [CNT_W-1:0] inflight;
  logic             acc_in, acc_out;

  assign acc_in  = din_valid && din_ready;
  assign acc_out = dout_valid && dout_ready;

  // words taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(acc_in) - CNT_W'(acc_out);
    end
  end

  a_sat: assert property (@(posedge clk) disable iff (rst)
    dout_valid && overflow |-> quotient_real == DATA_MAX && quotient_imag == DATA_MAX)
    else $error("overflow word not saturated");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !dout_valid)
    else $error("output valid after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    inflight == '0 |-> !dout_valid)
    else $error("word delivered that was never taken");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(PIPE_DEPTH))
    else $error("more words held than the pipeline has stages");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dout_valid && !dout_ready |=> dout_valid && $stable(quotient_real)
      && $stable(quotient_imag) && $stable(overflow))
    else $error("stalled output word changed");

endmodule

bind complex_divider cdiv_check u_cdiv_check (
  .clk           (clk),
  .rst           (rst),
  .din_valid     (din.valid),
  .din_ready     (din.ready),
  .dout_valid    (dout.valid),
  .dout_ready    (dout.ready),
  .quotient_real (dout.quotient_real),
  .quotient_imag (dout.quotient_imag),
  .overflow      (dout.overflow)
);

[tb/complex_divider_tb.sv]
`timescale 1ns / 100ps

module complex_divider_tb;
  import cdiv_pkg::*;

  localparam int          RANDOM_WORDS = 700;
  localparam int          HOLD_CYCLES  = 150;
  localparam int          BURST_START  = 200;
  localparam int          BURST_LEN    = 80;
  localparam int          DRAIN_AT     = 450;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  localparam data_t ZERO  = '0;
  localparam data_t ONE   = 32'sh0001_0000;
  localparam data_t LSB   = 32'sd1;
  localparam data_t V_MAX = DATA_MAX;
  localparam data_t V_MIN = 32'sh8000_0000;

  localparam logic signed [127:0] PART_MAX = (128'sd1 <<< (DATA_WIDTH - 1)) - 128'sd1;
  localparam logic signed [127:0] PART_MIN = -PART_MAX - 128'sd1;

  typedef struct packed {
    data_t re;
    data_t im;
    logic  ovf;
  } quot_t;

  typedef struct packed {
    data_t c;
    data_t d;
    data_t a;
    data_t b;
    bit    known;
    quot_t want;
  } step_t;

  localparam quot_t SATURATED = '{DATA_MAX, DATA_MAX, 1'b1};

  logic clk;
  logic rst;

  cdiv_in_if  din_bus ();
  cdiv_out_if dout_bus ();

  complex_divider i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_bus),
    .dout (dout_bus)
  );

  quot_t       quotient_q [$];
  int          mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          hold_req;
  bit          send_calm;
  bit          recv_calm;

  // directed words: (c + jd) / (a + jb), expected typed in where obvious
  step_t script [20] = '{
    '{ZERO,  ZERO,  ZERO,  ZERO,  1'b1, SATURATED},
    '{ONE,   ZERO,  ONE,   ZERO,  1'b1, '{ONE, ZERO, 1'b0}},
    '{ZERO,  ONE,   ZERO,  ONE,   1'b1, '{ONE, ZERO, 1'b0}},
    '{ONE,   ZERO,  ZERO,  ONE,   1'b1, '{ZERO, -ONE, 1'b0}},
    '{V_MIN, V_MIN, V_MIN, V_MIN, 1'b1, '{ONE, ZERO, 1'b0}},
    '{V_MAX, ZERO,  ONE,   ZERO,  1'b1, '{V_MAX, ZERO, 1'b0}},
    '{V_MIN, ZERO,  ONE,   ZERO,  1'b1, '{V_MIN, ZERO, 1'b0}},
    '{ZERO,  V_MIN, ONE,   ZERO,  1'b1, '{ZERO, V_MIN, 1'b0}},
    '{V_MIN, ZERO,  -ONE,  ZERO,  1'b1, SATURATED},
    '{V_MAX, V_MAX, ZERO,  ZERO,  1'b1, SATURATED},
    '{V_MAX, ZERO,  LSB,   ZERO,  1'b1, SATURATED},
    '{ZERO,  V_MAX, LSB,   ZERO,  1'b1, SATURATED},
    '{-LSB,  -LSB,  -LSB,  -LSB,  1'b1, '{ONE, ZERO, 1'b0}},
    '{ZERO,  ZERO,  V_MIN, ZERO,  1'b1, '{ZERO, ZERO, 1'b0}},
    '{-ONE,  ZERO,  32'sh0003_0000, ZERO, 1'b0, '0},
    '{V_MAX, V_MIN, V_MAX, V_MIN, 1'b0, '0},
    '{V_MIN, V_MAX, V_MAX, V_MIN, 1'b0, '0},
    '{LSB,   ZERO,  V_MAX, V_MAX, 1'b0, '0},
    '{ONE,   ONE,   ONE,   -ONE,  1'b0, '0},
    '{32'sh7FFF_0000, ZERO, 32'sh0000_8000, ZERO, 1'b0, '0}
  };

  // exact quotient of two complex Q16.16 values, truncated toward zero
  function automatic quot_t divide_complex(data_t c, data_t d, data_t a, data_t b);
    logic signed [127:0] sc, sd, sa, sb, mag2, num_re, num_im, part_re, part_im;
    quot_t r;
    sc = c;
    sd = d;
    sa = a;
    sb = b;
    mag2   = sa * sa + sb * sb;
    num_re = sc * sa + sd * sb;
    num_im = sd * sa - sc * sb;
    r = SATURATED;
    if (mag2 != 0) begin
      part_re = (num_re <<< FRAC_BITS) / mag2;
      part_im = (num_im <<< FRAC_BITS) / mag2;
      if (part_re >= PART_MIN && part_re <= PART_MAX &&
          part_im >= PART_MIN && part_im <= PART_MAX) begin
        r.re  = part_re[DATA_WIDTH-1:0];
        r.im  = part_im[DATA_WIDTH-1:0];
        r.ovf = 1'b0;
      end
    end
    return r;
  endfunction

  // one random field: full range, corner values or scaled-down magnitudes
  function automatic data_t pick_field();
    data_t v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ;
      4: begin
        case ($urandom_range(0, 6))
          0: v = ZERO;
          1: v = LSB;
          2: v = -LSB;
          3: v = V_MAX;
          4: v = V_MIN;
          5: v = ONE;
          default: v = -ONE;
        endcase
      end
      5, 6: v = v >>> $urandom_range(8, 30);
      default: v = v >>> $urandom_range(1, 16);
    endcase
    return v;
  endfunction

  function automatic int pause_len(bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // present one word and wait for it to be taken
  task automatic offer(input data_t c, input data_t d, input data_t a, input data_t b,
                       input quot_t want, input int gap);
    if (gap > 0) begin
      din_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_bus.valid         <= 1'b1;
    din_bus.dividend_real <= c;
    din_bus.dividend_imag <= d;
    din_bus.divisor_real  <= a;
    din_bus.divisor_imag  <= b;
    do @(posedge clk); while (!din_bus.ready);
    quotient_q.push_back(want);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("complex_divider verification failed");
      $finish;
    end
  end

  // sender: reset, directed table, then random words
  initial begin
    quot_t want;
    data_t c, d, a, b;
    int    gap;
    hold_req     = 1'b0;
    send_calm    = 1'b0;
    rst                   <= 1'b1;
    din_bus.valid         <= 1'b0;
    din_bus.dividend_real <= '0;
    din_bus.dividend_imag <= '0;
    din_bus.divisor_real  <= '0;
    din_bus.divisor_imag  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      want = script[i].known ? script[i].want :
             divide_complex(script[i].c, script[i].d, script[i].a, script[i].b);
      offer(script[i].c, script[i].d, script[i].a, script[i].b, want, pause_len(send_calm));
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 39) == 0)
        send_calm = !send_calm;
      // receiver holds off while words keep coming back to back
      if (n == BURST_START)
        hold_req = 1'b1;
      // let the pipeline run dry before going on
      if (n == DRAIN_AT) begin
        din_bus.valid <= 1'b0;
        do @(posedge clk); while (quotient_q.size() != 0);
      end
      c = pick_field();
      d = pick_field();
      if ($urandom_range(0, 19) == 0) begin
        a = ZERO;
        b = ZERO;
      end else begin
        a = pick_field();
        b = pick_field();
      end
      gap = (n >= BURST_START && n < BURST_START + BURST_LEN) ? 0 : pause_len(send_calm);
      offer(c, d, a, b, divide_complex(c, d, a, b), gap);
    end

    // wait for the last results, then a margin for stray words
    din_bus.valid <= 1'b0;
    do @(posedge clk); while (quotient_q.size() != 0);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (mismatch_cnt == 0 && quotient_q.size() == 0)
      $display("complex_divider verification clean");
    else
      $display("complex_divider verification failed");
    $finish;
  end

  // receiver: random stalls, one long hold on request
  initial begin
    int stall;
    bit held;
    recv_calm = 1'b0;
    held      = 1'b0;
    dout_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0)
        recv_calm = !recv_calm;
      if (hold_req && !held) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = pause_len(recv_calm);
      end
      if (stall > 0) begin
        dout_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dout_bus.ready <= 1'b1;
      do @(posedge clk); while (!dout_bus.valid);
    end
  end

  // compare each returned word with the oldest expected quotient
  always @(posedge clk) begin
    quot_t want;
    if (!rst && dout_bus.valid && dout_bus.ready) begin
      if (quotient_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected word: re %h im %h ovf %b", dout_bus.quotient_real,
                   dout_bus.quotient_imag, dout_bus.overflow);
      end else begin
        want = quotient_q.pop_front();
        if (dout_bus.quotient_real !== want.re || dout_bus.quotient_imag !== want.im ||
            dout_bus.overflow !== want.ovf) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected re %h im %h ovf %b, got re %h im %h ovf %b",
                     want.re, want.im, want.ovf, dout_bus.quotient_real,
                     dout_bus.quotient_imag, dout_bus.overflow);
        end
      end
    end
  end

endmodule
